/* hw/rtl/tdrq_pkg.sv */
// ----------------------------------------------------------------------------
// tdrq_pkg
// Shared types and codes for the tick delay release queue.
// ----------------------------------------------------------------------------
package tdrq_pkg;

  // request operation codes
  localparam logic [1:0] OP_QUERY     = 2'd0;
  localparam logic [1:0] OP_DELAY_REL = 2'd1;
  localparam logic [1:0] OP_DELAY_ABS = 2'd2;
  localparam logic [1:0] OP_UPDATE    = 2'd3;

  // reply status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_QUERY     = 3'd0,
    CMD_DELAY_REL = 3'd1,
    CMD_DELAY_ABS = 3'd2,
    CMD_UPDATE    = 3'd3,
    CMD_NEG       = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  id;
    logic [30:0] mag;
  } cmd_t;

  // one waiting requester
  typedef struct packed {
    logic [30:0] wake;
    logic [7:0]  id;
  } waiter_t;

endpackage

/* hw/rtl/tick_delay_release_queue_top.sv */
// ----------------------------------------------------------------------------
// tick_delay_release_queue_top
// Current tick plus a sorted queue of delayed requesters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the in channel (operation, requester_id, value) with
//   in_valid/in_stall; replies leave on the out channel with out_valid and
//   out_stall, one transfer per reply, last marking the final reply of a
//   request. A front stage classifies requests into a two-entry command
//   queue, so up to two requests are taken while the back is busy.
//   A query or error reply is taken from the command queue and registered
//   into the out channel when the back is idle. An insert holds the back
//   while it shifts each queued entry with a later wake tick one place
//   toward the tail (read, then compare and write, through the single-port
//   waiter memory). A tick update holds it while it reads the head, compares
//   and releases each due waiter; each memory read is registered.
//   Reset clears the tick, the queue and both channels; no clearing pass.
//   When the receiver stalls, the pending reply holds and the sequencer
//   waits; the command queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module tick_delay_release_queue_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         requester_id,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         target_id,
  output logic [30:0]        reply_value,
  output logic [1:0]         status,
  output logic               last
);
  import tdrq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // request classification and command queue
  tdrq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .requester_id (requester_id),
    .value        (value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // execution and reply generation
  tdrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .target_id   (target_id),
    .reply_value (reply_value),
    .status      (status),
    .last        (last)
  );

endmodule

/* hw/rtl/tdrq_front.sv */
// ----------------------------------------------------------------------------
// tdrq_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tdrq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [7:0]           requester_id,
  input  logic signed [31:0]   value,
  output logic                 cmd_valid,
  output tdrq_pkg::cmd_t       cmd,
  input  logic                 cmd_pop
);
  import tdrq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       push;

  // classify the incoming request
  always_comb begin
    cls.id  = requester_id;
    cls.mag = value[30:0];
    unique case (operation)
      OP_QUERY:     cls.kind = CMD_QUERY;
      OP_DELAY_REL: cls.kind = value[31] ? CMD_NEG : CMD_DELAY_REL;
      OP_DELAY_ABS: cls.kind = value[31] ? CMD_NEG : CMD_DELAY_ABS;
      OP_UPDATE:    cls.kind = value[31] ? CMD_NEG : CMD_UPDATE;
      default:      cls.kind = CMD_QUERY;
    endcase
  end

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  // command queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

/* hw/rtl/tdrq_back.sv */
// ----------------------------------------------------------------------------
// tdrq_back
// Executes commands: keeps the tick and a sorted waiter ring in memory,
// inserts by shifting from the tail and releases from the head.
// ----------------------------------------------------------------------------
module tdrq_back #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  tdrq_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           target_id,
  output logic [30:0]          reply_value,
  output logic [1:0]           status,
  output logic                 last
);
  import tdrq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_REL_RD  = 6'b001000,
    S_REL_CMP = 6'b010000,
    S_REL_FIN = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [30:0]   tick, tick_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  waiter_t       new_ent, new_ent_next;
  logic [7:0]    pend_id, pend_id_next;
  logic [30:0]   pend_val, pend_val_next;

  waiter_t       mem [QUEUE_DEPTH];
  waiter_t       rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  waiter_t       mem_wdata;

  logic          can_emit, emit;
  logic [7:0]    e_id;
  logic [30:0]   e_val;
  logic [1:0]    e_status;
  logic          e_last;

  logic [31:0]   rel_sum;
  logic [30:0]   rel_wake;
  logic [CW-1:0] pos_m1;
  logic [AW-1:0] addr_pos, addr_pos_m1, head_inc;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  assign can_emit    = !out_valid || !out_stall;
  assign rel_sum     = {1'b0, tick} + {1'b0, cmd.mag};
  assign rel_wake    = rel_sum[31] ? '1 : rel_sum[30:0];
  assign pos_m1      = pos - CW'(1);
  assign addr_pos    = wrap_add(head, pos[AW-1:0]);
  assign addr_pos_m1 = wrap_add(head, pos_m1[AW-1:0]);
  assign head_inc    = wrap_add(head, AW'(1));

  // command sequencer
  always_comb begin
    state_next    = state;
    tick_next     = tick;
    head_next     = head;
    count_next    = count;
    pos_next      = pos;
    new_ent_next  = new_ent;
    pend_id_next  = pend_id;
    pend_val_next = pend_val;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_id      = cmd.id;
    e_val     = '0;
    e_status  = ST_OK;
    e_last    = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = addr_pos;
    mem_wdata = new_ent;
    mem_re    = 1'b0;
    mem_raddr = addr_pos_m1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_QUERY: begin
              if (can_emit) begin
                cmd_pop = 1'b1;
                emit    = 1'b1;
                e_val   = tick;
              end
            end
            CMD_NEG: begin
              if (can_emit) begin
                cmd_pop  = 1'b1;
                emit     = 1'b1;
                e_status = ST_NEG;
              end
            end
            CMD_DELAY_REL, CMD_DELAY_ABS: begin
              if (count == DEPTH_C) begin
                if (can_emit) begin
                  cmd_pop  = 1'b1;
                  emit     = 1'b1;
                  e_status = ST_FULL;
                end
              end else begin
                cmd_pop         = 1'b1;
                new_ent_next.id = cmd.id;
                new_ent_next.wake = (cmd.kind == CMD_DELAY_REL) ? rel_wake : cmd.mag;
                pos_next        = count;
                state_next      = S_INS_RD;
              end
            end
            CMD_UPDATE: begin
              cmd_pop       = 1'b1;
              tick_next     = cmd.mag;
              pend_id_next  = cmd.id;
              pend_val_next = '0;
              state_next    = S_REL_RD;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      // walk back from the tail, reading and then comparing each entry
      S_INS_RD: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata.wake > new_ent.wake) begin
          mem_wdata  = rdata;
          pos_next   = pos_m1;
          state_next = S_INS_RD;
        end else begin
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end
      // release from the head while due
      S_REL_RD: begin
        if (count == '0) begin
          state_next = S_REL_FIN;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = head;
          state_next = S_REL_CMP;
        end
      end
      S_REL_CMP: begin
        if (rdata.wake <= tick) begin
          if (can_emit) begin
            emit          = 1'b1;
            e_id          = pend_id;
            e_val         = pend_val;
            e_last        = 1'b0;
            pend_id_next  = rdata.id;
            pend_val_next = tick;
            head_next     = head_inc;
            count_next    = count - CW'(1);
            state_next    = S_REL_RD;
          end
        end else begin
          state_next = S_REL_FIN;
        end
      end
      S_REL_FIN: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_id       = pend_id;
          e_val      = pend_val;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick  <= '0;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      tick  <= tick_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    new_ent  <= new_ent_next;
    pend_id  <= pend_id_next;
    pend_val <= pend_val_next;
  end

  // waiter memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      target_id   <= e_id;
      reply_value <= e_val;
      status      <= e_status;
      last        <= e_last;
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tick_delay_release_queue_top.
// Requests come from a queue of pending items and are driven onto the in
// channel. Each accepted request goes through a local copy of the tick and
// the wait queue, which yields the expected replies in order. The monitor
// compares each accepted reply, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
  import tdrq_pkg::*;

  localparam int DEPTH      = 32;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [30:0] TICK_TOP = 31'h7FFFFFFF;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  id;
    logic [31:0] val;
    bit          hold;   // wait for every reply before this one goes out
  } request_t;

  typedef struct {
    logic [7:0]  id;
    logic [30:0] val;
    logic [1:0]  st;
    logic        lst;
  } reply_t;

  typedef struct {
    logic [30:0] wake;
    logic [7:0]  id;
  } sleeper_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        operation = OP_QUERY;
  logic [7:0]        requester_id = '0;
  logic signed [31:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        target_id;
  logic [30:0]       reply_value;
  logic [1:0]        status;
  logic              last;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  sleeper_t sleepers[$];
  logic [30:0] model_tick = '0;

  int n_requests = 0;
  int n_replies  = 0;
  int n_full     = 0;
  int n_neg      = 0;
  int n_errors   = 0;
  int idle_phase = 0;
  int quiet_cycles = 0;
  logic [31:0] gen_tick = 0;

  tick_delay_release_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // update local tick and wait queue, queue up expected replies
  task automatic track_request(input logic [1:0] op, input logic [7:0] id,
                               input logic [31:0] raw);
    logic [31:0] sum;
    logic [30:0] wake;
    int pos;
    reply_t r;
    sleeper_t s;
    r.id = id; r.val = '0; r.st = ST_OK; r.lst = 1'b1;
    if (op == OP_QUERY) begin
      r.val = model_tick;
      expected_replies.push_back(r);
    end else if (raw[31]) begin
      r.st = ST_NEG;
      n_neg++;
      expected_replies.push_back(r);
    end else if (op == OP_UPDATE) begin
      model_tick = raw[30:0];
      expected_replies.push_back(r);
      while (sleepers.size() > 0 && sleepers[0].wake <= model_tick) begin
        expected_replies[$].lst = 1'b0;
        r.id = sleepers[0].id;
        r.val = model_tick;
        expected_replies.push_back(r);
        void'(sleepers.pop_front());
      end
    end else begin
      if (op == OP_DELAY_REL) begin
        sum = {1'b0, model_tick} + {1'b0, raw[30:0]};
        wake = sum[31] ? TICK_TOP : sum[30:0];
      end else begin
        wake = raw[30:0];
      end
      if (sleepers.size() >= DEPTH) begin
        r.st = ST_FULL;
        n_full++;
        expected_replies.push_back(r);
      end else begin
        // equal wake ticks keep arrival order
        pos = 0;
        while (pos < sleepers.size() && sleepers[pos].wake <= wake) pos++;
        s.wake = wake; s.id = id;
        sleepers.insert(pos, s);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(operation, requester_id, value);
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        go = pending_reqs.size() > 0;
        if (go && idle_phase == 0) go = $urandom_range(99) >= 8;
        if (go && idle_phase == 1) go = $urandom_range(99) >= 75;
        if (go && pending_reqs[0].hold && expected_replies.size() != 0) go = 0;
        if (go) begin
          operation    <= pending_reqs[0].op;
          requester_id <= pending_reqs[0].id;
          value        <= pending_reqs[0].val;
          void'(pending_reqs.pop_front());
        end
        in_valid <= go;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (idle_phase == 0) out_stall <= $urandom_range(99) < 75;
    else if (idle_phase == 1) out_stall <= $urandom_range(99) < 8;
    else out_stall <= 1'b0;
  end

  // reply checker
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      n_replies++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply id=%0d val=%0d st=%0d last=%0b",
                 $time, target_id, reply_value, status, last);
        n_errors++;
      end else begin
        e = expected_replies.pop_front();
        if (target_id !== e.id) begin
          $display("%0t: target_id expected %0d got %0d", $time, e.id, target_id);
          n_errors++;
        end
        if (reply_value !== e.val) begin
          $display("%0t: reply_value expected %0d got %0d", $time, e.val, reply_value);
          n_errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d got %0d", $time, e.st, status);
          n_errors++;
        end
        if (last !== e.lst) begin
          $display("%0t: last expected %0b got %0b", $time, e.lst, last);
          n_errors++;
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_req(input logic [1:0] op, input logic [7:0] id,
                                  input logic [31:0] v, input bit hold = 0);
    request_t q;
    q.op = op; q.id = id; q.val = v; q.hold = hold;
    pending_reqs.push_back(q);
    if (op == OP_UPDATE && !v[31]) gen_tick = v;
  endfunction

  // mostly short delays, some errors and some from the full range
  function automatic logic [31:0] pick_arg();
    int k;
    k = $urandom_range(99);
    if (k < 60) return $urandom_range(60);
    if (k < 75) return $urandom | 32'h80000000;
    if (k < 90) return $urandom;
    return 32'h7FFFFFFF - $urandom_range(40);
  endfunction

  task automatic build_random(input int count);
    int start, n;
    logic [1:0] op;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < count) begin
      if ($urandom_range(9) == 0) begin
        // fill the queue past its depth, then release everyone
        repeat (DEPTH + 2)
          add_req(OP_DELAY_ABS, 8'($urandom),
                  gen_tick[30:0] % 1000 + $urandom_range(50));
        add_req(OP_UPDATE, 8'($urandom), gen_tick[30:0] % 1000 + 100);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          op = 2'($urandom_range(2));
          add_req(op, 8'($urandom), pick_arg());
        end
        if ($urandom_range(9) == 0) add_req(OP_UPDATE, 8'($urandom), pick_arg());
        else add_req(OP_UPDATE, 8'($urandom), (gen_tick % 5000) + $urandom_range(80),
                     $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: errors, passed wake, equal wake order, saturation
    add_req(OP_QUERY, 8'h00, 32'h0);
    add_req(OP_UPDATE, 8'hFF, -32'sd5);
    add_req(OP_DELAY_REL, 8'h01, 32'hFFFFFFFF);
    add_req(OP_DELAY_ABS, 8'h02, 32'h80000000);
    add_req(OP_UPDATE, 8'h10, 32'd100);
    add_req(OP_DELAY_ABS, 8'h03, 32'd50);
    add_req(OP_DELAY_ABS, 8'h04, 32'd120);
    add_req(OP_DELAY_ABS, 8'h05, 32'd120);
    add_req(OP_DELAY_REL, 8'h06, 32'd20);
    add_req(OP_UPDATE, 8'h11, 32'd130);
    add_req(OP_UPDATE, 8'h12, 32'd2147483000);
    add_req(OP_DELAY_REL, 8'h07, 32'h7FFFFFFF);
    add_req(OP_QUERY, 8'hAA, 32'h55555555);
    add_req(OP_UPDATE, 8'h13, 32'h7FFFFFFF);
    add_req(OP_DELAY_ABS, 8'h08, 32'd0);
    add_req(OP_UPDATE, 8'h14, 32'd0, 1'b1);
    add_req(OP_QUERY, 8'h80, 32'hFFFFFFFF);

    // three idling patterns, about a third of the random items each
    build_random(70);
    wait_drained();
    idle_phase = 1;
    build_random(70);
    wait_drained();
    idle_phase = 2;
    build_random(70);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d requests, %0d replies checked", n_requests, n_replies);
    $display("error replies: %0d negative, %0d queue full", n_neg, n_full);
    if (n_errors == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* tick_delay_release_queue_top.f */
hw/rtl/tdrq_pkg.sv
hw/rtl/tdrq_front.sv
hw/rtl/tdrq_back.sv
hw/rtl/tick_delay_release_queue_top.sv
tb/tb.sv
